// File: rtl/cbm_pkg.sv
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned BANK_W     = 9;
  localparam int unsigned ROM_ADDR_W = 22;
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [BANK_W-1:0] MASK_RESET = 9'h1FF;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBMAPPER     = 2'd1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [2:0] MODE_32K_A    = 3'd0;
  localparam logic [2:0] MODE_16K_SPLIT = 3'd1;
  localparam logic [2:0] MODE_8K_A     = 3'd2;
  localparam logic [2:0] MODE_16K_A    = 3'd3;
  localparam logic [2:0] MODE_32K_B    = 3'd4;
  localparam logic [2:0] MODE_WINDOW   = 3'd5;
  localparam logic [2:0] MODE_8K_B     = 3'd6;
  localparam logic [2:0] MODE_16K_B    = 3'd7;

  typedef struct packed {
    logic [SLOTS-1:0][BANK_W-1:0] slot;
    logic [BANK_W-1:0]            window;
    logic                         mirror;
    logic                         chr_we;
  } bank_state_t;

endpackage

// File: rtl/cbm_bank_regs.sv
// bank, mirroring and chr write enable registers with the write decode
module cbm_bank_regs import cbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd_en,
  input  logic              submapper,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] data,
  output bank_state_t       state_r,
  output bank_state_t       state_nxt
);

  logic       in_window;
  logic [7:0] bank;
  logic [8:0] bank8;
  logic [6:0] bank32;
  logic [7:0] bank_hi;

  assign in_window = submapper ? (address[15:13] == 3'b111) : (address[15:12] == 4'hF);
  assign bank      = {address[12], address[4], data[5:0]};
  assign bank8     = {bank, data[7]};
  assign bank32    = bank[7:1];
  assign bank_hi   = bank | 8'h07;

  always_comb begin
    state_nxt = state_r;
    if (upd_en && in_window) begin
      state_nxt.mirror = data[6];
      state_nxt.chr_we = ~address[3];
      unique case (address[2:0]) inside
        MODE_32K_A, MODE_32K_B: begin
          for (int i = 0; i < SLOTS; i++) begin
            state_nxt.slot[i] = {bank32, i[1:0]};
          end
        end
        MODE_16K_SPLIT: begin
          state_nxt.slot[0] = {bank, 1'b0};
          state_nxt.slot[1] = {bank, 1'b1};
          state_nxt.slot[2] = {bank_hi, 1'b0};
          state_nxt.slot[3] = {bank_hi, 1'b1};
        end
        MODE_8K_A, MODE_8K_B: begin
          for (int i = 0; i < SLOTS; i++) begin
            state_nxt.slot[i] = bank8;
          end
        end
        MODE_16K_A, MODE_16K_B: begin
          state_nxt.slot[0] = {bank, 1'b0};
          state_nxt.slot[1] = {bank, 1'b1};
          state_nxt.slot[2] = {bank, 1'b0};
          state_nxt.slot[3] = {bank, 1'b1};
        end
        MODE_WINDOW: begin
          state_nxt.window = bank8;
          for (int i = 0; i < SLOTS; i++) begin
            state_nxt.slot[i] = {bank32 | 7'h03, i[1:0]};
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.slot[0] <= 9'd0;
      state_r.slot[1] <= 9'd1;
      state_r.slot[2] <= 9'd2;
      state_r.slot[3] <= 9'd3;
      state_r.window  <= '0;
      state_r.mirror  <= 1'b0;
      state_r.chr_we  <= 1'b1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/cbm_translate.sv
// read address translation into the program rom
module cbm_translate import cbm_pkg::*; (
  input  logic                  req_type,
  input  logic [ADDR_W-1:0]     address,
  input  bank_state_t           state,
  input  logic [BANK_W-1:0]     prg_bank_mask,
  output logic [ROM_ADDR_W-1:0] rom_address,
  output logic                  rom_hit
);

  logic              mapped;
  logic [BANK_W-1:0] bank;

  assign mapped = (req_type == REQ_READ) && (address[15] || (address[14:13] == 2'b11));
  assign bank   = address[15] ? state.slot[address[14:13]] : state.window;

  always_comb begin
    rom_address = '0;
    rom_hit     = 1'b0;
    if (mapped) begin
      rom_address = {bank & prg_bank_mask, address[12:0]};
      rom_hit     = 1'b1;
    end
  end

endmodule

// File: rtl/cartridge_bank_mapper.sv
// cartridge bank mapper top level: input stage, decode and result register
// path: input stage registers, decode, then the registered result on out_tdata
// throughput: one access per cycle unless out_tready stalls, single decode pass
// a new access is taken while a result waits if the input stage is empty or drains
// reset: synchronous active low; banks 0..3 in the slots, window bank 0,
// vertical mirroring, chr writes enabled, full bank mask, submapper 0
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // address[15:0], data[23:16]
  input  logic                   in_tuser,   // req_type[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // rom_address[21:0], rom_hit[22],
                                             // mirror_horizontal[23],
                                             // chr_write_enable[24], zero[31:25]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BANK_W-1:0]      cfg_data
);

  logic                   in_valid_r;
  logic                   in_valid_nxt;
  logic                   req_type_r;
  logic [ADDR_W-1:0]      address_r;
  logic [DATA_W-1:0]      data_r;
  logic                   advance;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [BANK_W-1:0]      mask_r;
  logic                   submapper_r;
  bank_state_t            bank_r;
  bank_state_t            bank_nxt;
  logic [ROM_ADDR_W-1:0]  rom_address;
  logic                   rom_hit;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= MASK_RESET;
      submapper_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRG_BANK_MASK: mask_r <= cfg_data;
          CFG_SUBMAPPER:     submapper_r <= cfg_data[0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_type_r <= in_tuser;
      address_r  <= in_tdata[15:0];
      data_r     <= in_tdata[23:16];
    end
    if (advance) begin
      out_data_r <= {7'd0, bank_nxt.chr_we, bank_nxt.mirror, rom_hit, rom_address};
    end
  end

  cbm_bank_regs u_bank_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (advance && (req_type_r == REQ_WRITE)),
    .submapper (submapper_r),
    .address   (address_r),
    .data      (data_r),
    .state_r   (bank_r),
    .state_nxt (bank_nxt)
  );

  cbm_translate u_translate (
    .req_type      (req_type_r),
    .address       (address_r),
    .state         (bank_r),
    .prg_bank_mask (mask_r),
    .rom_address   (rom_address),
    .rom_hit       (rom_hit)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[22] |-> out_data_r[21:0] == '0)
    else $error("unmapped result carries a rom address");

  a_bank_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[22] |-> (out_data_r[21:13] & ~mask_r) == '0)
    else $error("rom address bank outside mask");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> bank_r.chr_we && !bank_r.mirror && !in_valid_r && !out_valid_r)
    else $error("reset state wrong");

endmodule
